// ===== sv/bpt_pkg.sv =====
`default_nettype none
package bpt_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WEIGHT_W        = 32;
  localparam int TOL_W           = 16;
  // quotient bits: integer part below saturation plus one rounding bit
  localparam int QUOT_W          = WEIGHT_W + 1;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
  localparam logic signed [WEIGHT_W-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;

  // per-item classification handed from front to back
  typedef struct packed {
    logic neg0;
    logic neg1;
    logic sat0;
    logic sat1;
    logic degen;
  } flags_t;

endpackage
`default_nettype wire

// ===== sv/barycentric_point_in_triangle.sv =====
// Barycentric weights and inside test for one point and one triangle per item.
// Throughput: one item per cycle unless out_ready stalls the back end; the
// divider is a 33-stage restoring pipeline. Path from input accept to
// out_valid: 5 front stages, the queue, divider entry, 33 divide steps and 2
// finish stages. Reset (rst_n low, synchronous) empties all stages and the
// queue and sets inside_tolerance to 1.
`default_nettype none
module barycentric_point_in_triangle #(
  parameter int COORD_WIDTH = bpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = bpt_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [bpt_pkg::TOL_W-1:0]            cfg_inside_tolerance,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [COORD_WIDTH-1:0]        in_point_x,
  input  wire signed [COORD_WIDTH-1:0]        in_point_y,
  input  wire signed [COORD_WIDTH-1:0]        in_vertex0_x,
  input  wire signed [COORD_WIDTH-1:0]        in_vertex0_y,
  input  wire signed [COORD_WIDTH-1:0]        in_vertex1_x,
  input  wire signed [COORD_WIDTH-1:0]        in_vertex1_y,
  input  wire signed [COORD_WIDTH-1:0]        in_vertex2_x,
  input  wire signed [COORD_WIDTH-1:0]        in_vertex2_y,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [bpt_pkg::WEIGHT_W-1:0] out_weight0,
  output logic signed [bpt_pkg::WEIGHT_W-1:0] out_weight1,
  output logic signed [bpt_pkg::WEIGHT_W-1:0] out_weight2,
  output logic                                out_inside_res,
  output logic                                out_degenerate
);
  import bpt_pkg::*;

  localparam int MW = 2 * (COORD_WIDTH + 1);
  localparam int FW = $bits(flags_t);
  localparam int QW = 3 * MW + FW;

  logic [TOL_W-1:0] tol_r;
  logic q_full, q_empty, q_push, q_pop;
  logic [MW-1:0] f_n0, f_n1, f_d, b_n0, b_n1, b_d;
  flags_t f_fl, b_fl;
  logic [QW-1:0] q_wdata, q_rdata;

  // tolerance register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_inside_tolerance;
    end
  end

  bpt_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .px(in_point_x), .py(in_point_y),
    .v0x(in_vertex0_x), .v0y(in_vertex0_y),
    .v1x(in_vertex1_x), .v1y(in_vertex1_y),
    .v2x(in_vertex2_x), .v2y(in_vertex2_y),
    .q_full(q_full), .q_push(q_push),
    .nmag0(f_n0), .nmag1(f_n1), .dmag(f_d), .flags(f_fl)
  );

  assign q_wdata = {f_n0, f_n1, f_d, f_fl};
  assign {b_n0, b_n1, b_d, b_fl} = q_rdata;

  bpt_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .empty(q_empty)
  );

  bpt_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_pop(q_pop),
    .nmag0(b_n0), .nmag1(b_n1), .dmag(b_d), .flags(b_fl),
    .tol(tol_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .w0(out_weight0), .w1(out_weight1), .w2(out_weight2),
    .inside_res(out_inside_res), .degen(out_degenerate)
  );

endmodule
`default_nettype wire

// ===== sv/bpt_front.sv =====
`default_nettype none
module bpt_front #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire signed [COORD_WIDTH-1:0]       px,
  input  wire signed [COORD_WIDTH-1:0]       py,
  input  wire signed [COORD_WIDTH-1:0]       v0x,
  input  wire signed [COORD_WIDTH-1:0]       v0y,
  input  wire signed [COORD_WIDTH-1:0]       v1x,
  input  wire signed [COORD_WIDTH-1:0]       v1y,
  input  wire signed [COORD_WIDTH-1:0]       v2x,
  input  wire signed [COORD_WIDTH-1:0]       v2y,
  input  wire                                q_full,
  output logic                               q_push,
  output logic [2*(COORD_WIDTH+1)-1:0]       nmag0,
  output logic [2*(COORD_WIDTH+1)-1:0]       nmag1,
  output logic [2*(COORD_WIDTH+1)-1:0]       dmag,
  output bpt_pkg::flags_t                    flags
);
  import bpt_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int MW  = PW;
  localparam int SHW = WEIGHT_W - FRAC_BITS;

  logic adv;
  logic [4:0] v_r;

  // stage 1: coordinate differences
  logic signed [DW-1:0] ex1_r, ey2_r, ex2_r, ey1_r;
  logic signed [DW-1:0] a0_r, b0_r, a1_r, b1_r, a2_r, b2_r;
  // stage 2: products
  logic signed [PW-1:0] pd0_r, pd1_r, pn0a_r, pn0b_r, pn1a_r, pn1b_r;
  // stage 3: area and cross products
  logic signed [SW-1:0] ds_r, n0s_r, n1s_r;
  // stage 4: magnitudes and signs
  logic [MW-1:0] dm4_r, nm04_r, nm14_r;
  logic neg0_4_r, neg1_4_r, degen4_r;
  // stage 5: saturation test
  logic [MW-1:0] dm5_r, nm05_r, nm15_r;
  flags_t fl5_r;

  logic [MW+SHW-1:0] dsh;

  assign adv      = !v_r[4] || !q_full;
  assign in_ready = adv;
  assign q_push   = v_r[4] && !q_full;
  assign nmag0    = nm05_r;
  assign nmag1    = nm15_r;
  assign dmag     = dm5_r;
  assign flags    = fl5_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  assign dsh = {dm4_r, {SHW{1'b0}}};

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      ex1_r <= DW'(v1x) - DW'(v0x);
      ey2_r <= DW'(v2y) - DW'(v0y);
      ex2_r <= DW'(v2x) - DW'(v0x);
      ey1_r <= DW'(v1y) - DW'(v0y);
      a0_r  <= DW'(v0x) - DW'(px);
      b0_r  <= DW'(v0y) - DW'(py);
      a1_r  <= DW'(v1x) - DW'(px);
      b1_r  <= DW'(v1y) - DW'(py);
      a2_r  <= DW'(v2x) - DW'(px);
      b2_r  <= DW'(v2y) - DW'(py);

      pd0_r  <= PW'(ex1_r) * PW'(ey2_r);
      pd1_r  <= PW'(ex2_r) * PW'(ey1_r);
      pn0a_r <= PW'(a1_r) * PW'(b2_r);
      pn0b_r <= PW'(a2_r) * PW'(b1_r);
      pn1a_r <= PW'(a2_r) * PW'(b0_r);
      pn1b_r <= PW'(a0_r) * PW'(b2_r);

      ds_r  <= SW'(pd0_r) - SW'(pd1_r);
      n0s_r <= SW'(pn0a_r) - SW'(pn0b_r);
      n1s_r <= SW'(pn1a_r) - SW'(pn1b_r);

      dm4_r    <= ds_r[SW-1] ? MW'(-ds_r) : MW'(ds_r);
      nm04_r   <= n0s_r[SW-1] ? MW'(-n0s_r) : MW'(n0s_r);
      nm14_r   <= n1s_r[SW-1] ? MW'(-n1s_r) : MW'(n1s_r);
      neg0_4_r <= n0s_r[SW-1] ^ ds_r[SW-1];
      neg1_4_r <= n1s_r[SW-1] ^ ds_r[SW-1];
      degen4_r <= (ds_r == '0);

      dm5_r       <= dm4_r;
      nm05_r      <= nm04_r;
      nm15_r      <= nm14_r;
      fl5_r.neg0  <= neg0_4_r;
      fl5_r.neg1  <= neg1_4_r;
      fl5_r.degen <= degen4_r;
      // integer part at or above 2^(32-F) saturates
      fl5_r.sat0  <= ({{SHW{1'b0}}, nm04_r} >= dsh);
      fl5_r.sat1  <= ({{SHW{1'b0}}, nm14_r} >= dsh);
    end
  end

endmodule
`default_nettype wire

// ===== sv/bpt_queue.sv =====
`default_nettype none
module bpt_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire [W-1:0]  wdata,
  input  wire          pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import bpt_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [W-1:0] mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// ===== sv/bpt_back.sv =====
`default_nettype none
module bpt_back #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    q_empty,
  output logic                                   q_pop,
  input  wire [2*(COORD_WIDTH+1)-1:0]            nmag0,
  input  wire [2*(COORD_WIDTH+1)-1:0]            nmag1,
  input  wire [2*(COORD_WIDTH+1)-1:0]            dmag,
  input  bpt_pkg::flags_t                        flags,
  input  wire [bpt_pkg::TOL_W-1:0]               tol,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]    w0,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]    w1,
  output logic signed [bpt_pkg::WEIGHT_W-1:0]    w2,
  output logic                                   inside_res,
  output logic                                   degen
);
  import bpt_pkg::*;

  localparam int MW   = 2 * (COORD_WIDTH + 1);
  localparam int RW   = MW + 1;
  localparam int QB   = QUOT_W;
  localparam int FULW = QB + MW + FRAC_BITS + 1;
  localparam int EW   = WEIGHT_W + 2;
  localparam logic [QB-1:0] HALF = QB'(1) << (WEIGHT_W - 1);

  logic adv;
  logic [QB+2:0] v_r;

  logic [RW-1:0] rem0_r [QB+1];
  logic [RW-1:0] rem1_r [QB+1];
  logic [QB-1:0] qn0_r  [QB+1];
  logic [QB-1:0] qn1_r  [QB+1];
  logic [MW-1:0] d_r    [QB+1];
  flags_t        fl_r   [QB+1];

  logic [FULW-1:0] full0, full1;

  logic signed [WEIGHT_W-1:0] w0f_r, w1f_r;
  logic degf_r;
  logic [QB-1:0] mag0, mag1;
  logic signed [WEIGHT_W-1:0] w0n, w1n;
  logic signed [EW-1:0] sum, tol_s;

  assign adv       = !out_valid || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = v_r[QB+2];

  // numerator scaled by 2^(F+1); high part seeds the remainder
  assign full0 = {{QB{1'b0}}, nmag0, {(FRAC_BITS+1){1'b0}}};
  assign full1 = {{QB{1'b0}}, nmag1, {(FRAC_BITS+1){1'b0}}};

  // valid chain through divider and finish stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QB+1:0], q_pop};
    end
  end

  // divider entry
  always_ff @(posedge clk) begin
    if (adv) begin
      rem0_r[0] <= full0[QB+RW-1:QB];
      rem1_r[0] <= full1[QB+RW-1:QB];
      qn0_r[0]  <= full0[QB-1:0];
      qn1_r[0]  <= full1[QB-1:0];
      d_r[0]    <= dmag;
      fl_r[0]   <= flags;
    end
  end

  // one restoring step per stage, two lanes share the divisor;
  // numerator bits shift out of qn as quotient bits shift in
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [RW-1:0] sh0, sh1;
    logic ge0, ge1;
    assign sh0 = {rem0_r[i][RW-2:0], qn0_r[i][QB-1]};
    assign sh1 = {rem1_r[i][RW-2:0], qn1_r[i][QB-1]};
    assign ge0 = (sh0 >= {1'b0, d_r[i]});
    assign ge1 = (sh1 >= {1'b0, d_r[i]});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem0_r[i+1] <= ge0 ? sh0 - {1'b0, d_r[i]} : sh0;
        rem1_r[i+1] <= ge1 ? sh1 - {1'b0, d_r[i]} : sh1;
        qn0_r[i+1]  <= {qn0_r[i][QB-2:0], ge0};
        qn1_r[i+1]  <= {qn1_r[i][QB-2:0], ge1};
        d_r[i+1]    <= d_r[i];
        fl_r[i+1]   <= fl_r[i];
      end
    end
  end

  // round half away from zero, apply sign, saturate; degenerate gives zero
  assign mag0 = QB'(({1'b0, qn0_r[QB]} + 1'b1) >> 1);
  assign mag1 = QB'(({1'b0, qn1_r[QB]} + 1'b1) >> 1);

  always_comb begin
    if (fl_r[QB].degen)     w0n = '0;
    else if (fl_r[QB].sat0) w0n = fl_r[QB].neg0 ? W_MIN : W_MAX;
    else if (fl_r[QB].neg0) w0n = (mag0 >= HALF) ? W_MIN : -WEIGHT_W'(mag0);
    else                    w0n = (mag0 >= HALF) ? W_MAX : WEIGHT_W'(mag0);
    if (fl_r[QB].degen)     w1n = '0;
    else if (fl_r[QB].sat1) w1n = fl_r[QB].neg1 ? W_MIN : W_MAX;
    else if (fl_r[QB].neg1) w1n = (mag1 >= HALF) ? W_MIN : -WEIGHT_W'(mag1);
    else                    w1n = (mag1 >= HALF) ? W_MAX : WEIGHT_W'(mag1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0f_r  <= w0n;
      w1f_r  <= w1n;
      degf_r <= fl_r[QB].degen;
    end
  end

  // tolerance scaled to the weight fraction
  if (FRAC_BITS >= TOL_W) begin : g_tol_up
    assign tol_s = EW'(tol) << (FRAC_BITS - TOL_W);
  end else begin : g_tol_dn
    assign tol_s = EW'(tol >> (TOL_W - FRAC_BITS));
  end

  assign sum = (EW'(1) <<< FRAC_BITS) - EW'(w0f_r) - EW'(w1f_r);

  // third weight, inside test, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      w0    <= w0f_r;
      w1    <= w1f_r;
      degen <= degf_r;
      if (degf_r)                 w2 <= '0;
      else if (sum > EW'(W_MAX))  w2 <= W_MAX;
      else if (sum < EW'(W_MIN))  w2 <= W_MIN;
      else                        w2 <= WEIGHT_W'(sum);
      inside_res <= !degf_r && (EW'(w0f_r) >= -tol_s) && (EW'(w1f_r) >= -tol_s)
                    && (sum >= -tol_s);
    end
  end

endmodule
`default_nettype wire

// ===== tb/bpt_checker.sv =====
`timescale 1ns / 100ps
// Watches the config, input and result channels of the triangle block,
// predicts every result from the accepted input items and compares.
module bpt_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire [15:0]        cfg_inside_tolerance,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire signed [19:0] in_point_x,
  input  wire signed [19:0] in_point_y,
  input  wire signed [19:0] in_vertex0_x,
  input  wire signed [19:0] in_vertex0_y,
  input  wire signed [19:0] in_vertex1_x,
  input  wire signed [19:0] in_vertex1_y,
  input  wire signed [19:0] in_vertex2_x,
  input  wire signed [19:0] in_vertex2_y,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [31:0] out_weight0,
  input  wire signed [31:0] out_weight1,
  input  wire signed [31:0] out_weight2,
  input  wire               out_inside_res,
  input  wire               out_degenerate,
  output int                fail_count,
  output int                pending,
  output int                n_checked,
  output int                n_inside,
  output int                n_degen,
  output int                n_sat
);
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int FRAC = 16;

  typedef struct packed {
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    logic               inside_res;
    logic               degen;
  } weights_t;

  weights_t  weights_q[$];
  logic [15:0] tolerance;

  function automatic longint clamp32(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  // rounded fixed-point quotient, ties away from zero, saturated
  function automatic longint fix_quotient(longint num, longint den);
    logic neg;
    longint unsigned n, d, ip, r, mag;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    ip = n / d;
    r = n % d;
    if (ip >= (64'd1 << (32 - FRAC))) return neg ? WMIN : WMAX;
    mag = ip;
    for (int i = 0; i < FRAC + 1; i++) begin
      r = r << 1;
      mag = mag << 1;
      if (r >= d) begin
        r = r - d;
        mag = mag | 64'd1;
      end
    end
    mag = (mag + 1) >> 1;
    if (neg) return (mag >= (64'd1 << 31)) ? WMIN : -longint'(mag);
    return (mag > 64'd2147483647) ? WMAX : longint'(mag);
  endfunction

  function automatic weights_t bary_weights(longint px, longint py, longint x0, longint y0,
                                            longint x1, longint y1, longint x2, longint y2,
                                            logic [15:0] tol16);
    weights_t res;
    longint den, a0, b0, a1, b1, a2, b2, w0, w1, w2, tol;
    a0 = x0 - px; b0 = y0 - py;
    a1 = x1 - px; b1 = y1 - py;
    a2 = x2 - px; b2 = y2 - py;
    den = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    res = '0;
    if (den == 0) begin
      res.degen = 1'b1;
      return res;
    end
    w0 = fix_quotient(a1 * b2 - a2 * b1, den);
    w1 = fix_quotient(a2 * b0 - a0 * b2, den);
    w2 = clamp32((64'sd1 <<< FRAC) - w0 - w1);
    tol = longint'(tol16);
    res.w0 = w0[31:0];
    res.w1 = w1[31:0];
    res.w2 = w2[31:0];
    res.inside_res = (w0 >= -tol) && (w1 >= -tol) && (w2 >= -tol);
    return res;
  endfunction

  // config tracking, prediction on input accept, compare on result accept
  always @(posedge clk) begin
    weights_t exp_w, got;
    if (!rst_n) begin
      tolerance <= 16'd1;
      weights_q.delete();
      pending <= 0;
      fail_count <= 0;
      n_checked <= 0;
      n_inside <= 0;
      n_degen <= 0;
      n_sat <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_inside_tolerance;
      if (in_valid && in_ready)
        weights_q.push_back(bary_weights(in_point_x, in_point_y, in_vertex0_x, in_vertex0_y,
                                         in_vertex1_x, in_vertex1_y, in_vertex2_x,
                                         in_vertex2_y, tolerance));
      if (out_valid && out_ready) begin
        got = '{out_weight0, out_weight1, out_weight2, out_inside_res, out_degenerate};
        if (weights_q.size() == 0) begin
          $display("%0t unexpected item: weight0 %0d weight1 %0d weight2 %0d", $time,
                   out_weight0, out_weight1, out_weight2);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = weights_q.pop_front();
          n_checked <= n_checked + 1;
          if (exp_w.inside_res) n_inside <= n_inside + 1;
          if (exp_w.degen) n_degen <= n_degen + 1;
          if (exp_w.w0 == 32'sh7fff_ffff || exp_w.w0 == 32'sh8000_0000 ||
              exp_w.w1 == 32'sh7fff_ffff || exp_w.w1 == 32'sh8000_0000)
            n_sat <= n_sat + 1;
          if (got != exp_w) begin
            fail_count <= fail_count + 1;
            if (got.w0 != exp_w.w0)
              $display("%0t weight0 expected %0d got %0d", $time, exp_w.w0, got.w0);
            if (got.w1 != exp_w.w1)
              $display("%0t weight1 expected %0d got %0d", $time, exp_w.w1, got.w1);
            if (got.w2 != exp_w.w2)
              $display("%0t weight2 expected %0d got %0d", $time, exp_w.w2, got.w2);
            if (got.inside_res != exp_w.inside_res)
              $display("%0t inside_res expected %0d got %0d", $time, exp_w.inside_res,
                       got.inside_res);
            if (got.degen != exp_w.degen)
              $display("%0t degenerate expected %0d got %0d", $time, exp_w.degen,
                       got.degen);
          end
        end
      end
      pending <= weights_q.size();
    end
  end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  localparam int CMAX = 524287;
  localparam int CMIN = -524288;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_inside_tolerance = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [19:0] crd [8];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_weight0, out_weight1, out_weight2;
  logic out_inside_res, out_degenerate;

  int fail_count, pending, n_checked, n_inside, n_degen, n_sat;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_arm = 0;
  int n_sent = 0;

  initial for (int i = 0; i < 8; i++) crd[i] = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  barycentric_point_in_triangle dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_inside_tolerance(cfg_inside_tolerance),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(crd[0]), .in_point_y(crd[1]),
    .in_vertex0_x(crd[2]), .in_vertex0_y(crd[3]),
    .in_vertex1_x(crd[4]), .in_vertex1_y(crd[5]),
    .in_vertex2_x(crd[6]), .in_vertex2_y(crd[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_weight0(out_weight0), .out_weight1(out_weight1), .out_weight2(out_weight2),
    .out_inside_res(out_inside_res), .out_degenerate(out_degenerate)
  );

  bpt_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_inside_tolerance(cfg_inside_tolerance),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(crd[0]), .in_point_y(crd[1]),
    .in_vertex0_x(crd[2]), .in_vertex0_y(crd[3]),
    .in_vertex1_x(crd[4]), .in_vertex1_y(crd[5]),
    .in_vertex2_x(crd[6]), .in_vertex2_y(crd[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_weight0(out_weight0), .out_weight1(out_weight1), .out_weight2(out_weight2),
    .out_inside_res(out_inside_res), .out_degenerate(out_degenerate),
    .fail_count(fail_count), .pending(pending), .n_checked(n_checked),
    .n_inside(n_inside), .n_degen(n_degen), .n_sat(n_sat)
  );

  // result side: random stalls, plus a long hold-off when armed
  initial begin
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_arm != hold_seen) begin
        hold_seen = hold_arm;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    #3000000;
    $display("barycentric_point_in_triangle: mismatch");
    $finish;
  end

  // offer one item; called right after a rising edge
  task automatic send_tri(int px, int py, int x0, int y0, int x1, int y1, int x2, int y2);
    int gap;
    logic acc;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    crd[0] <= px[19:0]; crd[1] <= py[19:0];
    crd[2] <= x0[19:0]; crd[3] <= y0[19:0];
    crd[4] <= x1[19:0]; crd[5] <= y1[19:0];
    crd[6] <= x2[19:0]; crd[7] <= y2[19:0];
    forever begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
      if (acc) break;
    end
    n_sent++;
  endtask

  // let the checker count the last accepted item before polling pending
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] val);
    logic acc;
    drain();
    cfg_valid <= 1'b1;
    cfg_inside_tolerance <= val;
    forever begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
      if (acc) break;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rnd_full();
    return int'($urandom) >>> 12;
  endfunction

  // mix of full-range, small, collinear and far-point triangles
  task automatic send_random();
    int kind, ox, oy, x0, y0, x1, y1, x2, y2, px, py, k;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_tri(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
               rnd_full(), rnd_full());
    end else if (kind < 75) begin
      ox = $urandom_range(0, 1000000) - 500000;
      oy = $urandom_range(0, 1000000) - 500000;
      x0 = ox + $urandom_range(0, 600) - 300; y0 = oy + $urandom_range(0, 600) - 300;
      x1 = ox + $urandom_range(0, 600) - 300; y1 = oy + $urandom_range(0, 600) - 300;
      x2 = ox + $urandom_range(0, 600) - 300; y2 = oy + $urandom_range(0, 600) - 300;
      px = ox + $urandom_range(0, 400) - 200; py = oy + $urandom_range(0, 400) - 200;
      send_tri(px, py, x0, y0, x1, y1, x2, y2);
    end else if (kind < 87) begin
      x0 = $urandom_range(0, 2000) - 1000; y0 = $urandom_range(0, 2000) - 1000;
      x1 = x0 + $urandom_range(0, 200) - 100; y1 = y0 + $urandom_range(0, 200) - 100;
      k = $urandom_range(0, 6) - 3;
      x2 = x0 + k * (x1 - x0); y2 = y0 + k * (y1 - y0);
      send_tri(rnd_full(), rnd_full(), x0, y0, x1, y1, x2, y2);
    end else begin
      x0 = rnd_full(); y0 = rnd_full();
      send_tri(rnd_full(), rnd_full(), x0, y0, x0 + $urandom_range(0, 4) - 2,
               y0 + $urandom_range(0, 4) - 2, x0 + $urandom_range(0, 4) - 2,
               y0 + $urandom_range(0, 4) - 2);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: basic cases and coordinate extremes, reset tolerance
    send_tri(1, 1, 0, 0, 4, 0, 0, 4);
    send_tri(0, 0, 0, 0, 4, 0, 0, 4);
    send_tri(2, 0, 0, 0, 4, 0, 0, 4);
    send_tri(5, 5, 0, 0, 4, 0, 0, 4);
    send_tri(1, 1, 0, 0, 0, 4, 4, 0);
    send_tri(7, 7, 3, 3, 3, 3, 3, 3);
    send_tri(0, 0, 1, 1, 2, 2, 5, 5);
    send_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_tri(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
    send_tri(0, 0, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
    send_tri(CMIN, CMAX, 0, 0, 1, 0, 0, 1);
    send_tri(CMAX, CMIN, 0, 0, 1, 0, 0, 1);
    send_tri(CMIN, CMIN, CMAX, CMAX, CMAX - 1, CMAX, CMAX, CMAX - 1);
    send_tri(CMAX, 0, CMIN, 0, CMIN, 1, CMIN + 1, 0);
    send_tri(1, 1, 0, 0, 3, 0, 0, 3);
    send_tri(-1, 0, 0, 0, 65536, 0, 0, 65536);
    send_tri(0, -1, 0, 0, 300000, 0, 0, 300000);

    // tolerance at zero, then at its top; boundary items reused
    write_tolerance(16'd0);
    send_tri(-1, 0, 0, 0, 65536, 0, 0, 65536);
    send_tri(2, 0, 0, 0, 4, 0, 0, 4);
    write_tolerance(16'hffff);
    send_tri(5, 5, 0, 0, 4, 0, 0, 4);
    send_tri(-3, 1, 0, 0, 4, 0, 0, 4);

    // random phases with varied idling and tolerance
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          send_idle = 0; recv_stall = 0;
        end
        1: begin
          send_idle = 65; recv_stall = 0;
          write_tolerance(16'd0);
        end
        2: begin
          send_idle = 0; recv_stall = 65;
          write_tolerance(16'($urandom));
        end
        3: begin
          send_idle = 26; recv_stall = 26;
          write_tolerance(16'h8000);
        end
        default: begin
          send_idle = 0; recv_stall = 0;
          write_tolerance(16'd1);
          hold_arm = hold_arm + 1;
        end
      endcase
      repeat (90) send_random();
    end

    drain();
    $display("items sent %0d, results checked %0d", n_sent, n_checked);
    $display("inside %0d, degenerate %0d, saturated %0d", n_inside, n_degen, n_sat);
    if (fail_count == 0) begin
      $display("barycentric_point_in_triangle: match");
    end else begin
      $display("barycentric_point_in_triangle: mismatch");
    end
    $finish;
  end
endmodule
